@@ sv/ttpr_pkg.sv @@
// Shared types, codes and widths for the transposition table probe/record unit.
`default_nettype none

package ttpr_pkg;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 17;
  localparam int OP_W    = 2;
  localparam int BOUND_W = 2;

  // Default table size (power of two)
  localparam int TABLE_SLOTS_DEF = 4096;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Bound kinds
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

  // One table slot
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [BOUND_W-1:0] bound;
    logic [DEPTH_W-1:0] depth;
  } slot_t;

  // Controller to datapath commands
  typedef struct packed {
    logic req_load;   // capture accepted request
    logic mem_rd;     // read slot at the request's index
    logic mem_wr;     // write request's entry at the request's index
    logic sweep_clr;  // restart the clearing sweep at slot 0
    logic sweep_wr;   // zero the slot at the sweep address and advance
    logic out_load;   // load the response register
  } ttpr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sweep_last;
    logic            out_free;
  } ttpr_sts_t;

endpackage

`default_nettype wire

@@ sv/ttpr_ifs.sv @@
// Request and response channel interfaces for the transposition table unit.
`default_nettype none

interface ttpr_in_if import ttpr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [KEY_W-1:0]          position_key;
  logic [DEPTH_W-1:0]        search_depth;
  logic signed [SCORE_W-1:0] entry_score;
  logic [BOUND_W-1:0]        bound_kind;
  logic signed [SCORE_W-1:0] window_low;
  logic signed [SCORE_W-1:0] window_high;

  modport source (
    output valid, operation, position_key, search_depth, entry_score,
           bound_kind, window_low, window_high,
    input  ready
  );
  modport sink (
    input  valid, operation, position_key, search_depth, entry_score,
           bound_kind, window_low, window_high,
    output ready
  );
endinterface

interface ttpr_out_if import ttpr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [SCORE_W-1:0] result_score;

  modport source (output valid, hit, result_score, input ready);
  modport sink   (input valid, hit, result_score, output ready);
endinterface

`default_nettype wire

@@ sv/transposition_table_probe_record_unit.sv @@
// Top level of the transposition table probe/record unit.
// Direct-mapped, always-replace table of TABLE_SLOTS entries (key, score, bound, depth)
// held in one single-port-write, registered-read memory. TABLE_SLOTS must be a power of
// two: the slot is the low bits of the key. Each request returns exactly one response.
// A probe, record or unused operation steps through accept, index/memory access and
// response states; the response register loads once it is free, and the next request
// can be accepted on the following edge, so no new request is taken until the previous
// one has loaded its response. A clear zeroes the memory one slot per cycle and then
// loads its response. After reset the same clearing pass runs with in_chan.ready low.
// Only one request is in flight; the response register lets the next request be
// accepted while the previous response is still waiting on out_chan, and a further
// response waits in the response state until that register frees up.
`default_nettype none

module transposition_table_probe_record_unit import ttpr_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ttpr_in_if.sink    in_chan,
  ttpr_out_if.source out_chan
);

  ttpr_cmd_t cmd;
  ttpr_sts_t sts;
  logic      ready;

  assign in_chan.ready = ready;

  // Sequencer
  ttpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Table storage and compare logic
  ttpr_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

@@ sv/ttpr_dp.sv @@
// Datapath: request registers, slot memory, hit logic, response register.
`default_nettype none

module ttpr_dp import ttpr_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ttpr_in_if.sink   in_chan,
  ttpr_out_if.source out_chan,
  input  ttpr_cmd_t cmd,
  output ttpr_sts_t sts
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(TABLE_SLOTS - 1);

  // Captured request
  logic [OP_W-1:0]           op_r;
  logic [KEY_W-1:0]          key_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [BOUND_W-1:0]        bound_r;
  logic signed [SCORE_W-1:0] alpha_r;
  logic signed [SCORE_W-1:0] beta_r;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r    <= in_chan.operation;
      key_r   <= in_chan.position_key;
      depth_r <= in_chan.search_depth;
      score_r <= in_chan.entry_score;
      bound_r <= in_chan.bound_kind;
      alpha_r <= in_chan.window_low;
      beta_r  <= in_chan.window_high;
    end
  end

  // Slot index = key mod TABLE_SLOTS; the table is a power of two, so the low key bits
  logic [IDX_W-1:0] slot_idx;

  assign slot_idx = key_r[IDX_W-1:0];

  // Clearing sweep address
  logic [IDX_W-1:0] sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_clr) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  // Slot memory: one write port, one registered read port
  slot_t            mem [TABLE_SLOTS];
  slot_t            rd_r;
  slot_t            wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  always_comb begin
    wr_en   = cmd.mem_wr || cmd.sweep_wr;
    wr_addr = cmd.sweep_wr ? sweep_r : slot_idx;
    if (cmd.sweep_wr) begin
      wr_data = '0;
    end else begin
      wr_data.key   = key_r;
      wr_data.score = score_r;
      wr_data.bound = bound_r;
      wr_data.depth = depth_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_r <= mem[slot_idx];
    end
  end

  // Probe decision from the slot just read
  logic                      hit_c;
  logic signed [SCORE_W-1:0] res_c;
  logic signed [SCORE_W-1:0] slot_score;

  always_comb begin
    slot_score = $signed(rd_r.score);
    hit_c      = 1'b0;
    res_c      = '0;
    if (op_r == OP_PROBE && rd_r.key == key_r && rd_r.depth >= depth_r) begin
      case (rd_r.bound)
        BOUND_EXACT: begin
          hit_c = 1'b1;
          res_c = slot_score;
        end
        BOUND_UPPER: begin
          if (slot_score <= alpha_r) begin
            hit_c = 1'b1;
            res_c = alpha_r;
          end
        end
        BOUND_LOWER: begin
          if (slot_score >= beta_r) begin
            hit_c = 1'b1;
            res_c = beta_r;
          end
        end
        default: begin
          hit_c = 1'b0;
          res_c = '0;
        end
      endcase
    end
  end

  // Response register
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic signed [SCORE_W-1:0] out_score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r   <= hit_c;
      out_score_r <= res_c;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.hit          = out_hit_r;
  assign out_chan.result_score = out_score_r;

  // Status back to the controller
  assign sts.op         = op_r;
  assign sts.sweep_last = (sweep_r == LAST_C);
  assign sts.out_free   = !out_valid_r || out_chan.ready;

endmodule

`default_nettype wire

@@ sv/ttpr_ctrl.sv @@
// Controller: sequences slot access, clearing sweep and response.
`default_nettype none

module ttpr_ctrl import ttpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output ttpr_cmd_t cmd,
  input  ttpr_sts_t sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       resp_pend_r, resp_pend_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    resp_pend_nxt = resp_pend_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = ST_INDEX;
        end
      end
      ST_INDEX: begin
        case (sts.op)
          OP_PROBE: begin
            cmd.mem_rd = 1'b1;
            state_nxt  = ST_RESP;
          end
          OP_RECORD: begin
            cmd.mem_wr = 1'b1;
            state_nxt  = ST_RESP;
          end
          OP_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            resp_pend_nxt = 1'b1;
            state_nxt     = ST_SWEEP;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          resp_pend_nxt = 1'b0;
          state_nxt     = resp_pend_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Reset starts with a full clearing sweep and no response owed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      resp_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resp_pend_r <= resp_pend_nxt;
    end
  end

endmodule

`default_nettype wire
